[hdl/nca_pkg.sv]
// nca_pkg: widths, op codes and default sizes for the nearest centroid assign block.
// No dependencies; compiled first.
package nca_pkg;

    localparam int VAL_W = 16;
    localparam int SQ_W  = 32;
    localparam int SUM_W = 38;
    localparam int CL_W  = 3;
    localparam int DIM_W = 5;
    localparam int K_W   = 4;

    localparam int MAX_CLUSTERS_DEF = 8;
    localparam int MAX_DIMS_DEF     = 32;

    localparam logic OP_CENTROID = 1'b0;
    localparam logic OP_POINT    = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [SQ_W-1:0]         sq_t;
    typedef logic [SUM_W-1:0]        sum_t;

endpackage

[hdl/nca_in_if.sv]
// nca_in_if: input stream channel (centroid loads and point elements).
// Depends on nca_pkg.
interface nca_in_if import nca_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             op;
    logic [CL_W-1:0]  cluster_index;
    logic [DIM_W-1:0] dim_index;
    val_t             element_value;
    logic             point_last;

    modport source (output valid, op, cluster_index, dim_index, element_value, point_last,
                    input ready);
    modport sink   (input valid, op, cluster_index, dim_index, element_value, point_last,
                    output ready);

endinterface

[hdl/nca_out_if.sv]
// nca_out_if: result stream channel carrying the nearest cluster index.
// Depends on nca_pkg.
interface nca_out_if import nca_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [CL_W-1:0] nearest_cluster;

    modport source (output valid, nearest_cluster, input ready);
    modport sink   (input valid, nearest_cluster, output ready);

endinterface

[hdl/nearest_centroid_assign.sv]
// nearest_centroid_assign: k-means assignment step, streaming distance accumulate and argmin.
// Depends on nca_pkg, nca_in_if, nca_out_if.
//
//  channel   dir  transfer when         payload
//  in_ch     in   valid & ready         op, cluster_index, dim_index, element_value, point_last
//  out_ch    out  valid & ready         nearest_cluster
//  cfg       in   cfg_wr_en             cfg_wr_data = active_clusters
//
// One item per cycle while in_ch is ready; results pass p1, p2, snap_reg and the out buffer.
// Pipeline: centroid lane RAM read, square, saturating accumulate, argmin tree.
// After reset a clearing pass zeroes every centroid lane entry, in_ch not ready.
// A 2-entry output buffer keeps input open while a result waits; the pipeline
// stalls only when both entries are full and out_ch is not ready.
module nearest_centroid_assign
    import nca_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int MAX_DIMS     = MAX_DIMS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [K_W-1:0] cfg_wr_data,
    nca_in_if.sink         in_ch,
    nca_out_if.source      out_ch
);

    localparam int DAW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int IDXW = $clog2(MAX_CLUSTERS);
    localparam int NP   = 1 << IDXW;
    localparam int NN   = 2 * NP - 1;

    logic [K_W-1:0] active_clusters_reg;

    logic           clr_active_reg;
    logic [DAW-1:0] clr_cnt_reg;

    logic           adv;
    logic           accept;
    logic           dim_ok;
    logic [DAW-1:0] dim_addr;

    logic p1_valid_reg, p1_last_reg;
    val_t p1_val_reg;
    val_t rd_reg [MAX_CLUSTERS];

    logic p2_valid_reg, p2_last_reg;
    sq_t  sq_reg  [MAX_CLUSTERS];
    sq_t  sq_next [MAX_CLUSTERS];

    sum_t sum_reg  [MAX_CLUSTERS];
    sum_t sum_next [MAX_CLUSTERS];

    logic p3_valid_reg;
    sum_t snap_reg [MAX_CLUSTERS];

    logic [CL_W-1:0] best_idx;

    logic [1:0]      out_cnt_reg;
    logic [CL_W-1:0] out_head_reg;
    logic [CL_W-1:0] out_skid_reg;
    logic            push, pop;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_clusters_reg <= K_W'(1);
        else if (cfg_wr_en)
            active_clusters_reg <= cfg_wr_data;
    end

    // centroid clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + DAW'(1);
            if (clr_cnt_reg == DAW'(MAX_DIMS - 1))
                clr_active_reg <= 1'b0;
        end
    end

    assign adv         = (out_cnt_reg != 2'd2) || out_ch.ready;
    assign in_ch.ready = adv && !clr_active_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign dim_ok      = int'(in_ch.dim_index) < MAX_DIMS;
    assign dim_addr    = DAW'(in_ch.dim_index);

    // per-cluster centroid lanes
    for (genvar c = 0; c < MAX_CLUSTERS; c++)
    begin : g_lane
        val_t           mem [MAX_DIMS];
        logic           we;
        logic [DAW-1:0] waddr;
        val_t           wdata;

        assign we    = clr_active_reg ||
                       (accept && in_ch.op == OP_CENTROID && dim_ok &&
                        int'(in_ch.cluster_index) == c);
        assign waddr = clr_active_reg ? clr_cnt_reg : dim_addr;
        assign wdata = clr_active_reg ? val_t'(0) : in_ch.element_value;

        always_ff @(posedge clk)
        begin
            if (we)
                mem[waddr] <= wdata;
            if (accept && in_ch.op == OP_POINT)
                rd_reg[c] <= dim_ok ? mem[dim_addr] : val_t'(0);
        end
    end

    // stage 1 to 2: squared difference
    always_comb
    begin
        logic signed [VAL_W:0] diff;
        logic        [VAL_W:0] mag;
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            diff       = {p1_val_reg[VAL_W-1], p1_val_reg} - {rd_reg[c][VAL_W-1], rd_reg[c]};
            mag        = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
            sq_next[c] = mag[VAL_W-1:0] * mag[VAL_W-1:0];
        end
    end

    // stage 2 to 3: saturating accumulate
    always_comb
    begin
        logic [SUM_W:0] wide;
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            wide        = {1'b0, sum_reg[c]} + (SUM_W+1)'(sq_reg[c]);
            sum_next[c] = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            p2_valid_reg <= 1'b0;
            p2_last_reg  <= 1'b0;
            p3_valid_reg <= 1'b0;
            for (int c = 0; c < MAX_CLUSTERS; c++)
                sum_reg[c] <= '0;
        end
        else if (adv)
        begin
            p1_valid_reg <= accept && in_ch.op == OP_POINT;
            p1_last_reg  <= in_ch.point_last;
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_last_reg;
            p3_valid_reg <= p2_valid_reg && p2_last_reg;
            if (p2_valid_reg)
            begin
                for (int c = 0; c < MAX_CLUSTERS; c++)
                    sum_reg[c] <= p2_last_reg ? sum_t'(0) : sum_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
                p1_val_reg <= in_ch.element_value;
            for (int c = 0; c < MAX_CLUSTERS; c++)
                sq_reg[c] <= sq_next[c];
            if (p2_valid_reg && p2_last_reg)
            begin
                for (int c = 0; c < MAX_CLUSTERS; c++)
                    snap_reg[c] <= sum_next[c];
            end
        end
    end

    // stage 3: argmin tree, left child wins ties so the lower index is kept
    always_comb
    begin
        sum_t            node_val [NN];
        logic            node_act [NN];
        logic [IDXW-1:0] node_idx [NN];
        logic            take_r;
        for (int i = 0; i < NP; i++)
        begin
            node_idx[NP-1+i] = IDXW'(i);
            if (i < MAX_CLUSTERS)
            begin
                node_val[NP-1+i] = snap_reg[i];
                node_act[NP-1+i] = (i == 0) || (i < int'(active_clusters_reg));
            end
            else
            begin
                node_val[NP-1+i] = '0;
                node_act[NP-1+i] = 1'b0;
            end
        end
        for (int n = NP - 2; n >= 0; n--)
        begin
            take_r = node_act[2*n+2] &&
                     (!node_act[2*n+1] || node_val[2*n+2] < node_val[2*n+1]);
            node_val[n] = take_r ? node_val[2*n+2] : node_val[2*n+1];
            node_idx[n] = take_r ? node_idx[2*n+2] : node_idx[2*n+1];
            node_act[n] = node_act[2*n+1] || node_act[2*n+2];
        end
        best_idx = CL_W'(node_idx[0]);
    end

    // 2-entry output buffer
    assign push = adv && p3_valid_reg;
    assign pop  = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_cnt_reg <= 2'd0;
        else if (push && !pop)
            out_cnt_reg <= out_cnt_reg + 2'd1;
        else if (pop && !push)
            out_cnt_reg <= out_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        case (out_cnt_reg)
            2'd0:
            begin
                if (push)
                    out_head_reg <= best_idx;
            end
            2'd1:
            begin
                if (push && pop)
                    out_head_reg <= best_idx;
                else if (push)
                    out_skid_reg <= best_idx;
            end
            2'd2:
            begin
                if (pop)
                    out_head_reg <= out_skid_reg;
                if (push)
                    out_skid_reg <= best_idx;
            end
            default:
            begin
                out_head_reg <= out_head_reg;
            end
        endcase
    end

    assign out_ch.valid           = out_cnt_reg != 2'd0;
    assign out_ch.nearest_cluster = out_head_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !in_ch.ready)
        else $error("input ready during centroid clearing pass");

    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd3)
        else $error("output buffer overfilled");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_cnt_reg == 2'd2 && !out_ch.ready) |-> !in_ch.ready)
        else $error("input open while output buffer full and stalled");

    a_last_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.op == OP_POINT && in_ch.point_last) |=> (p1_valid_reg && p1_last_reg))
        else $error("last point element lost entering pipeline");

endmodule
